/* rtl/ippd_pkg.sv */
// shared types and constants for the incremental pid pwm motor drive
`timescale 1ns / 1ps

package ippd_pkg;

    localparam int GAIN_W       = 8;
    localparam int POS_W        = 8;
    localparam int DUTY_FIELD_W = 4;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 8;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_P = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_I = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_D = 2'd2;

    // word kinds
    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    typedef struct packed {
        logic             func;
        logic [POS_W-1:0] set_point;
        logic [POS_W-1:0] measured;
    } in_word_t;

    typedef struct packed {
        logic [DUTY_FIELD_W-1:0] duty;
        logic                    drive_a;
        logic                    drive_b;
        logic                    enable;
    } out_word_t;

    // control decisions from the pid calculation
    typedef struct packed {
        logic dir_load;
        logic drive_a;
        logic drive_b;
        logic hist_shift;
    } pid_ctl_t;

endpackage

/* rtl/ippd_pid.sv */
// incremental pid law: error, history shift decision and next duty
`timescale 1ns / 1ps

module ippd_pid #(
    parameter int DUTY_LIMIT  = 10,
    parameter int ERROR_LIMIT = 10,
    parameter int DUTY_W      = 4,
    parameter int ERR_W       = 4
) (
    input  logic [ippd_pkg::POS_W-1:0]  set_point,
    input  logic [ippd_pkg::POS_W-1:0]  measured,
    input  logic [ippd_pkg::GAIN_W-1:0] gain_p,
    input  logic [ippd_pkg::GAIN_W-1:0] gain_i,
    input  logic [ippd_pkg::GAIN_W-1:0] gain_d,
    input  logic [ERR_W-1:0]            err_now,
    input  logic [ERR_W-1:0]            err_prev,
    input  logic [DUTY_W-1:0]           duty,
    output ippd_pkg::pid_ctl_t          ctl,
    output logic [ERR_W-1:0]            err_new,
    output logic [DUTY_W-1:0]           duty_next
);

    localparam int D2_W  = ERR_W + 1;
    localparam int PRD_W = ippd_pkg::GAIN_W + D2_W;
    localparam int SUM_W = PRD_W + 2;

    logic [ippd_pkg::POS_W-1:0] err_abs;
    logic                       sp_above;
    logic                       differ;
    logic                       over;
    logic [ERR_W-1:0]           e0;
    logic                       d1_pos;
    logic [ERR_W-1:0]           d1;
    logic [D2_W-1:0]            sum02;
    logic [D2_W-1:0]            twice;
    logic                       d2_pos;
    logic [D2_W-1:0]            d2;
    logic [PRD_W-1:0]           prod_p;
    logic [PRD_W-1:0]           prod_i;
    logic [PRD_W-1:0]           prod_d;
    logic [SUM_W-1:0]           pos;
    logic [SUM_W-1:0]           neg;
    logic [SUM_W-1:0]           net;

    always_comb
    begin
        sp_above = set_point > measured;
        differ   = set_point != measured;
        err_abs  = sp_above ? set_point - measured : measured - set_point;
        over     = err_abs > ippd_pkg::POS_W'(ERROR_LIMIT);
        e0       = ERR_W'(err_abs);

        // history after the shift: e0 new, e1 = err_now, e2 = err_prev
        d1_pos = e0 > err_now;
        d1     = d1_pos ? e0 - err_now : err_now - e0;
        sum02  = D2_W'(e0) + D2_W'(err_prev);
        twice  = {err_now, 1'b0};
        d2_pos = sum02 > twice;
        d2     = d2_pos ? sum02 - twice : twice - sum02;

        prod_p = PRD_W'(gain_p) * PRD_W'(d1);
        prod_i = PRD_W'(gain_i) * PRD_W'(e0);
        prod_d = PRD_W'(gain_d) * PRD_W'(d2);

        pos = SUM_W'(prod_i) + SUM_W'(duty)
            + (d1_pos ? SUM_W'(prod_p) : '0)
            + (d2_pos ? SUM_W'(prod_d) : '0);
        neg = (d1_pos ? '0 : SUM_W'(prod_p))
            + (d2_pos ? '0 : SUM_W'(prod_d));
        net = pos - neg;

        ctl.dir_load   = differ;
        ctl.drive_a    = !sp_above;
        ctl.drive_b    = sp_above;
        ctl.hist_shift = differ && !over;
        err_new        = e0;

        if (!differ)
        begin
            duty_next = duty;
        end
        else if (over)
        begin
            duty_next = DUTY_W'(DUTY_LIMIT);
        end
        else if (pos > neg)
        begin
            duty_next = (net < SUM_W'(DUTY_LIMIT)) ? DUTY_W'(net) : DUTY_W'(DUTY_LIMIT);
        end
        else
        begin
            duty_next = duty;
        end
    end

endmodule

/* rtl/ippd_pwm.sv */
// pwm tick: counter advance with wrap and bridge enable level
`timescale 1ns / 1ps

module ippd_pwm #(
    parameter int PWM_PERIOD = 40,
    parameter int CNT_W      = 6,
    parameter int DUTY_W     = 4
) (
    input  logic [CNT_W-1:0]  count,
    input  logic [DUTY_W-1:0] duty,
    output logic [CNT_W-1:0]  count_next,
    output logic              enable_next
);

    localparam int CMP_W = (CNT_W > DUTY_W) ? CNT_W : DUTY_W;

    logic [CNT_W-1:0] count_inc;
    logic             below;

    always_comb
    begin
        count_inc = count + CNT_W'(1);
        below     = CMP_W'(count_inc) <= CMP_W'(duty);
        // at the wrap the level is inverted, as in the original controller
        if (count_inc == CNT_W'(PWM_PERIOD))
        begin
            count_next  = '0;
            enable_next = !below;
        end
        else
        begin
            count_next  = count_inc;
            enable_next = below;
        end
    end

endmodule

/* rtl/incremental_pid_pwm_motor_drive.sv */
// top level: input stage, controller state, result register and gain registers
//
//  port group          direction  payload
//  in_valid/in_ready   in         in_word  (func, set_point, measured)
//  out_valid/out_ready out        out_word (duty, drive_a, drive_b, enable)
//  cfg_valid/cfg_ready in         cfg_index, cfg_data (gain_p, gain_i, gain_d)
//
// a word is registered in the input stage and its result in the result register,
// and one word can be taken every cycle while the result is not stalled
// the three gain multiplies and the signed sum sit between input and result register
// reset clears history, duty and counter, and sets drive_a, drive_b and enable high
// a stalled result holds the input stage; cfg_ready is always high
`timescale 1ns / 1ps

module incremental_pid_pwm_motor_drive #(
    parameter int PWM_PERIOD  = 40,
    parameter int DUTY_LIMIT  = 10,
    parameter int ERROR_LIMIT = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ippd_pkg::in_word_t                  in_word,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ippd_pkg::out_word_t                 out_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ippd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ippd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DUTY_W = $clog2(DUTY_LIMIT + 1);
    localparam int ERR_W  = $clog2(ERROR_LIMIT + 1);
    localparam int CNT_W  = $clog2(PWM_PERIOD + 1);

    logic                           in_valid_reg;
    ippd_pkg::in_word_t             in_word_reg;
    logic                           out_valid_reg;
    ippd_pkg::out_word_t            out_word_reg;
    ippd_pkg::out_word_t            out_word_next;
    logic [ippd_pkg::GAIN_W-1:0]    gain_p_reg;
    logic [ippd_pkg::GAIN_W-1:0]    gain_i_reg;
    logic [ippd_pkg::GAIN_W-1:0]    gain_d_reg;
    logic [ERR_W-1:0]               err_now_reg;
    logic [ERR_W-1:0]               err_prev_reg;
    logic [ERR_W-1:0]               err_prev2_reg;
    logic [DUTY_W-1:0]              duty_reg;
    logic [DUTY_W-1:0]              duty_next;
    logic [CNT_W-1:0]               tick_count_reg;
    logic [CNT_W-1:0]               tick_count_next;
    logic                           drive_a_reg;
    logic                           drive_a_next;
    logic                           drive_b_reg;
    logic                           drive_b_next;
    logic                           enable_reg;
    logic                           enable_next;

    logic                           advance;
    logic                           is_tick;
    ippd_pkg::pid_ctl_t             pid_ctl;
    logic [ERR_W-1:0]               pid_err;
    logic [DUTY_W-1:0]              pid_duty;
    logic [CNT_W-1:0]               pwm_count;
    logic                           pwm_enable;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign cfg_ready = 1'b1;
    assign is_tick   = in_word_reg.func == ippd_pkg::FUNC_TICK;

    ippd_pid #(
        .DUTY_LIMIT  (DUTY_LIMIT),
        .ERROR_LIMIT (ERROR_LIMIT),
        .DUTY_W      (DUTY_W),
        .ERR_W       (ERR_W)
    ) u_pid (
        .set_point (in_word_reg.set_point),
        .measured  (in_word_reg.measured),
        .gain_p    (gain_p_reg),
        .gain_i    (gain_i_reg),
        .gain_d    (gain_d_reg),
        .err_now   (err_now_reg),
        .err_prev  (err_prev_reg),
        .duty      (duty_reg),
        .ctl       (pid_ctl),
        .err_new   (pid_err),
        .duty_next (pid_duty)
    );

    ippd_pwm #(
        .PWM_PERIOD (PWM_PERIOD),
        .CNT_W      (CNT_W),
        .DUTY_W     (DUTY_W)
    ) u_pwm (
        .count       (tick_count_reg),
        .duty        (duty_reg),
        .count_next  (pwm_count),
        .enable_next (pwm_enable)
    );

    always_comb
    begin
        duty_next       = duty_reg;
        tick_count_next = tick_count_reg;
        drive_a_next    = drive_a_reg;
        drive_b_next    = drive_b_reg;
        enable_next     = enable_reg;
        if (is_tick)
        begin
            tick_count_next = pwm_count;
            enable_next     = pwm_enable;
        end
        else
        begin
            duty_next = pid_duty;
            if (pid_ctl.dir_load)
            begin
                drive_a_next = pid_ctl.drive_a;
                drive_b_next = pid_ctl.drive_b;
            end
        end
        out_word_next.duty    = ippd_pkg::DUTY_FIELD_W'(duty_next);
        out_word_next.drive_a = drive_a_next;
        out_word_next.drive_b = drive_b_next;
        out_word_next.enable  = enable_next;
    end

    // handshake and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            err_now_reg    <= '0;
            err_prev_reg   <= '0;
            err_prev2_reg  <= '0;
            duty_reg       <= '0;
            tick_count_reg <= '0;
            drive_a_reg    <= 1'b1;
            drive_b_reg    <= 1'b1;
            enable_reg     <= 1'b1;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                duty_reg       <= duty_next;
                tick_count_reg <= tick_count_next;
                drive_a_reg    <= drive_a_next;
                drive_b_reg    <= drive_b_next;
                enable_reg     <= enable_next;
                if (!is_tick && pid_ctl.hist_shift)
                begin
                    err_prev2_reg <= err_prev_reg;
                    err_prev_reg  <= err_now_reg;
                    err_now_reg   <= pid_err;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ippd_pkg::CFG_GAIN_P: gain_p_reg <= cfg_data;
                ippd_pkg::CFG_GAIN_I: gain_i_reg <= cfg_data;
                ippd_pkg::CFG_GAIN_D: gain_d_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_word_reg <= in_word;
        end
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    a_duty_capped: assert property (@(posedge clk) disable iff (!rst_n)
        duty_reg <= DUTY_W'(DUTY_LIMIT))
        else $error("duty above limit");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        tick_count_reg < CNT_W'(PWM_PERIOD))
        else $error("pwm counter out of range");

    a_no_brake: assert property (@(posedge clk) disable iff (!rst_n)
        drive_a_reg || drive_b_reg)
        else $error("both bridge inputs low");

    a_equal_holds: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !is_tick && (in_word_reg.set_point == in_word_reg.measured)
        |=> $stable(duty_reg) && $stable(err_now_reg) && $stable(drive_a_reg))
        else $error("equal positions changed controller state");

endmodule
